[design/lkv_pkg.sv]
// shared types and constants for the lru key-value cache
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;

	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	// one request as held during the scan
	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} result_t;

	typedef struct packed {
		logic             en;
		idx_t             addr;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} ram_wr_t;

	typedef struct packed {
		logic             en;
		idx_t             addr;
	} ram_rd_t;

endpackage

[design/lkv_entry_ram.sv]
// key and value storage, one write port and one registered read port
module lkv_entry_ram
	import lkv_pkg::*;
(
	input  logic             clk,
	input  ram_wr_t          wr,
	input  ram_rd_t          rd,
	output logic [KEY_W-1:0] rd_key,
	output logic [VAL_W-1:0] rd_value
);

	logic [KEY_W+VAL_W-1:0] mem_q [ENTRIES];
	logic [KEY_W+VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= {wr.key, wr.value};
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_key   = rd_data_q[KEY_W+VAL_W-1:VAL_W];
	assign rd_value = rd_data_q[VAL_W-1:0];

endmodule

[design/lkv_ctrl.sv]
// request sequencer: entry scan, valid and recency state, commit of one request
module lkv_ctrl
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	input  logic             out_free,
	output logic             commit,
	output result_t          result,
	output ram_wr_t          ram_wr,
	output ram_rd_t          ram_rd,
	input  logic [KEY_W-1:0] rd_key,
	input  logic [VAL_W-1:0] rd_value
);

	state_t state_q, state_d;

	req_t             req_q;
	idx_t             addr_q;
	logic             proc_s1;
	idx_t             idx_s1;
	logic             valid_q [ENTRIES];
	idx_t             rank_q  [ENTRIES];
	logic [CNT_W-1:0] fill_q;

	// scan trackers
	logic             found_q;
	idx_t             found_idx_q;
	idx_t             found_rank_q;
	logic [VAL_W-1:0] found_val_q;
	logic             vic_any_q;
	idx_t             vic_idx_q;
	idx_t             vic_rank_q;
	logic [KEY_W-1:0] vic_key_q;
	logic             free_any_q;
	idx_t             free_idx_q;

	logic             scan_last;
	logic             start;
	logic             ent_valid;
	idx_t             ent_rank;
	logic             do_evict;
	logic             set_miss;
	idx_t             slot;
	logic             valid_d [ENTRIES];
	idx_t             rank_d  [ENTRIES];

	assign scan_last = (addr_q == idx_t'(ENTRIES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_SCAN;
			ST_SCAN:   if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_ready   = 1'b0;
		ram_rd.en   = 1'b0;
		ram_rd.addr = addr_q;
		commit      = 1'b0;
		case (state_q)
			ST_IDLE:   req_ready = 1'b1;
			ST_SCAN:   ram_rd.en = 1'b1;
			ST_DRAIN:  ;
			ST_COMMIT: commit = out_free;
			default:   ;
		endcase
	end

	assign start       = req_valid && req_ready;
	assign ent_valid   = valid_q[idx_s1];
	assign ent_rank    = rank_q[idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			proc_s1 <= 1'b0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			proc_s1 <= ram_rd.en;
			if (start) begin
				addr_q <= '0;
			end else if (ram_rd.en) begin
				addr_q <= addr_q + idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (start) begin
			req_q <= req;
		end
	end

	// compare each entry as its read data returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			vic_any_q  <= 1'b0;
			free_any_q <= 1'b0;
		end else if (start) begin
			found_q    <= 1'b0;
			vic_any_q  <= 1'b0;
			free_any_q <= 1'b0;
		end else if (proc_s1) begin
			if (ent_valid && rd_key == req_q.key && !found_q) begin
				found_q <= 1'b1;
			end
			if (ent_valid && (!vic_any_q || ent_rank > vic_rank_q)) begin
				vic_any_q <= 1'b1;
			end
			if (!ent_valid) begin
				free_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1) begin
			if (ent_valid && rd_key == req_q.key && !found_q) begin
				found_idx_q  <= idx_s1;
				found_rank_q <= ent_rank;
				found_val_q  <= rd_value;
			end
			if (ent_valid && (!vic_any_q || ent_rank > vic_rank_q)) begin
				vic_idx_q  <= idx_s1;
				vic_rank_q <= ent_rank;
				vic_key_q  <= rd_key;
			end
			if (!ent_valid && !free_any_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// decision at commit
	assign set_miss = req_q.mode && !found_q;
	assign do_evict = set_miss && vic_any_q && (fill_q >= CNT_W'(capacity));

	always_comb begin
		if (free_any_q) begin
			slot = (do_evict && vic_idx_q < free_idx_q) ? vic_idx_q : free_idx_q;
		end else begin
			slot = vic_idx_q;
		end
	end

	always_comb begin
		result.hit         = found_q;
		result.read_value  = req_q.mode ? req_q.value : (found_q ? found_val_q : MISS_VALUE);
		result.evicted     = do_evict;
		result.evicted_key = do_evict ? vic_key_q : '0;
	end

	always_comb begin
		ram_wr.en    = commit && req_q.mode;
		ram_wr.addr  = found_q ? found_idx_q : slot;
		ram_wr.key   = req_q.key;
		ram_wr.value = req_q.value;
	end

	// per-entry valid and recency update
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_d[i] = valid_q[i];
			rank_d[i]  = rank_q[i];
			if (found_q) begin
				if (idx_t'(i) == found_idx_q) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && rank_q[i] < found_rank_q) begin
					rank_d[i] = rank_q[i] + idx_t'(1);
				end
			end else if (set_miss) begin
				if (idx_t'(i) == slot) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end else if (do_evict && idx_t'(i) == vic_idx_q) begin
					valid_d[i] = 1'b0;
					rank_d[i]  = '0;
				end else if (valid_q[i]) begin
					rank_d[i] = rank_q[i] + idx_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (commit) begin
			if (set_miss && !do_evict) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= valid_d[i];
				rank_q[i]  <= rank_d[i];
			end
		end
	end

endmodule

[design/lru_key_value_cache.sv]
// lru key-value cache top level: stream ports, capacity register, result register
//
// requests enter on the s_ side: s_tuser is the mode (0 get, 1 set), s_tdata holds
// key in bits 31:0 and value in bits 63:32. results leave on the m_ side, one per
// request, in request order: m_tuser holds hit (bit 0) and evicted (bit 1), m_tdata
// holds read_value in bits 31:0 and evicted_key in bits 63:32.
// the capacity register (1..16 entries, 0 acts as 1, larger values as 16) is written
// through cfg_valid/cfg_ready/cfg_data; the user must do so only while no request is
// in flight, as the block itself does not enforce it. each request scans all 16
// entries of the key/value memory, one read per cycle, then passes the drain state
// and commits its update in the commit state, which loads the result register. a new
// request is taken only after the previous one has committed.
// a finished result waits in the output register while the next request is already
// scanning; if m_tready stays low the next request holds before its commit.
// reset clears all entries to invalid, empties the cache and sets capacity to 16.
module lru_key_value_cache
	import lkv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [KEY_W+VAL_W-1:0] s_tdata,   // key, value
	input  logic                   s_tuser,   // mode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [VAL_W+KEY_W-1:0] m_tdata,   // read_value, evicted_key
	output logic [1:0]             m_tuser,   // hit, evicted
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CAP_W-1:0]       cfg_data
);

	logic [CAP_W-1:0] active_q;
	logic [CAP_W-1:0] capacity;
	logic             out_free;
	logic             commit;
	result_t          result;
	result_t          out_q;
	logic             m_tvalid_q;
	req_t             req;
	ram_wr_t          ram_wr;
	ram_rd_t          ram_rd;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CAP_W'(ENTRIES);
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	always_comb begin
		if (active_q == '0) begin
			capacity = CAP_W'(1);
		end else if (active_q > CAP_W'(ENTRIES)) begin
			capacity = CAP_W'(ENTRIES);
		end else begin
			capacity = active_q;
		end
	end

	assign req.mode  = s_tuser;
	assign req.key   = s_tdata[KEY_W-1:0];
	assign req.value = s_tdata[KEY_W+VAL_W-1:KEY_W];

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.capacity  (capacity),
		.out_free  (out_free),
		.commit    (commit),
		.result    (result),
		.ram_wr    (ram_wr),
		.ram_rd    (ram_rd),
		.rd_key    (rd_key),
		.rd_value  (rd_value)
	);

	lkv_entry_ram u_ram (
		.clk      (clk),
		.wr       (ram_wr),
		.rd       (ram_rd),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.evicted_key, out_q.read_value};
	assign m_tuser  = {out_q.evicted, out_q.hit};

endmodule
